// ===== hdl/assert_macros.svh =====
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while rst is high.
`define ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// Next-cycle implication, disabled while rst is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hdl/htsi_pkg.sv =====
`default_nettype none

package htsi_pkg;

   localparam int CharWidth   = 8;
   localparam int ValueWidth  = 32;
   localparam int StatusWidth = 2;
   localparam int RspWidth    = 40;   // value + status, padded to whole bytes

   typedef logic [StatusWidth-1:0] status_type;

   localparam status_type StatusOk       = 2'd0;
   localparam status_type StatusEmpty    = 2'd1;
   localparam status_type StatusOverflow = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/hex_text_to_signed_int_unit.sv =====
`default_nettype none
// Latency: a result appears in the cycle after the item with tlast is accepted.
// Throughput: one character per cycle while req_tready is high; the digit update
// (shift by four, add, 36-bit limit compare) fits between the parse state and
// the result register. req_tready drops only while a result waits and rsp_tready is low.
// Reset (synchronous, active high) returns the parser to the start of a string
// and empties the result register.

module hex_text_to_signed_int_unit (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [htsi_pkg::CharWidth-1:0]  req_tdata,   // [7:0] character
   input  wire logic                            req_tlast,
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [htsi_pkg::RspWidth-1:0]   rsp_tdata    // [31:0] value, [33:32] status
);
   import htsi_pkg::*;

   typedef enum logic [2:0] {
      PhStart    = 3'd0,
      PhSign     = 3'd1,
      PhZero     = 3'd2,
      PhDigits   = 3'd3,
      PhStopped  = 3'd4,
      PhOverflow = 3'd5,
      PhEmpty    = 3'd6
   } phase_type;

   localparam logic [7:0] CharNul   = 8'h00;
   localparam logic [7:0] CharPlus  = 8'h2B;
   localparam logic [7:0] CharMinus = 8'h2D;
   localparam logic [7:0] CharZero  = 8'h30;
   localparam logic [7:0] CharNine  = 8'h39;
   localparam logic [7:0] CharUpA   = 8'h41;
   localparam logic [7:0] CharUpF   = 8'h46;
   localparam logic [7:0] CharLowA  = 8'h61;
   localparam logic [7:0] CharLowF  = 8'h66;
   localparam logic [7:0] CharLowX  = 8'h78;

   localparam logic [35:0] PosLimit = 36'h07FFFFFFF;
   localparam logic [35:0] NegLimit = 36'h080000000;

   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [ValueWidth-1:0]  acc_ff, acc_in;

   logic                   rsp_valid_ff;
   logic [ValueWidth-1:0]  rsp_value_ff, rsp_value_in;
   status_type             rsp_status_ff, rsp_status_in;

   logic                   accept;
   logic [7:0]             ch;
   logic                   dig_ok;
   logic [3:0]             dig_val;
   logic [35:0]            acc_next;
   logic [35:0]            limit;
   logic                   take;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign ch         = req_tdata;

   // hex digit decode, either case
   always_comb begin
      dig_ok  = 1'b0;
      dig_val = 4'd0;
      if (ch >= CharZero && ch <= CharNine) begin
         dig_ok  = 1'b1;
         dig_val = 4'(ch - CharZero);
      end else if (ch >= CharLowA && ch <= CharLowF) begin
         dig_ok  = 1'b1;
         dig_val = 4'(ch - CharLowA + 8'd10);
      end else if (ch >= CharUpA && ch <= CharUpF) begin
         dig_ok  = 1'b1;
         dig_val = 4'(ch - CharUpA + 8'd10);
      end
   end

   // accumulator stays at or below 0x80000000, so acc*16 + digit fits in 36 bits
   assign acc_next = {acc_ff, 4'h0} + {32'd0, dig_val};
   assign limit    = negative_ff ? NegLimit : PosLimit;

   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      acc_in      = acc_ff;
      take        = 1'b0;

      unique case (phase_ff)
         PhStart: begin
            if (ch == CharNul) begin
               phase_in = PhEmpty;
            end else if (ch == CharPlus || ch == CharMinus) begin
               negative_in = (ch == CharMinus);
               phase_in    = PhSign;
            end else if (ch == CharZero) begin
               phase_in = PhZero;
            end else begin
               take = 1'b1;
            end
         end
         PhSign: begin
            if (ch == CharZero) begin
               phase_in = PhZero;
            end else begin
               take = 1'b1;
            end
         end
         PhZero: begin
            if (ch == CharLowX) begin
               phase_in = PhDigits;
            end else begin
               take = 1'b1;
            end
         end
         PhDigits: begin
            take = 1'b1;
         end
         default: begin
            // stopped, overflow, empty: characters are ignored until last
         end
      endcase

      if (take) begin
         if (!dig_ok) begin
            phase_in = PhStopped;
         end else if (acc_next > limit) begin
            phase_in = PhOverflow;
            acc_in   = '0;
         end else begin
            acc_in   = acc_next[ValueWidth-1:0];
            phase_in = PhDigits;
         end
      end

      if (phase_in == PhEmpty) begin
         rsp_value_in  = '0;
         rsp_status_in = StatusEmpty;
      end else if (phase_in == PhOverflow) begin
         rsp_value_in  = '0;
         rsp_status_in = StatusOverflow;
      end else begin
         rsp_value_in  = negative_in ? (ValueWidth'(0) - acc_in) : acc_in;
         rsp_status_in = StatusOk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PhStart;
         negative_ff  <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            if (req_tlast) begin
               phase_ff    <= PhStart;
               negative_ff <= 1'b0;
               acc_ff      <= '0;
            end else begin
               phase_ff    <= phase_in;
               negative_ff <= negative_in;
               acc_ff      <= acc_in;
            end
         end
         if (accept && req_tlast) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept && req_tlast) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RspWidth - ValueWidth - StatusWidth){1'b0}},
                        rsp_status_ff, rsp_value_ff};

endmodule

`default_nettype wire

// ===== hdl/htsi_checker.sv =====
`default_nettype none
`include "assert_macros.svh"

module htsi_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tvalid,
   input wire logic                            req_tready,
   input wire logic                            req_tlast,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [htsi_pkg::RspWidth-1:0]   rsp_tdata
);
   import htsi_pkg::*;

   logic                  req_acc;
   logic                  rsp_free;
   status_type            status;
   logic [ValueWidth-1:0] value;

   assign req_acc  = req_tvalid && req_tready;
   assign rsp_free = !rsp_tvalid || rsp_tready;
   assign status   = rsp_tdata[ValueWidth +: StatusWidth];
   assign value    = rsp_tdata[ValueWidth-1:0];

   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `ASSERT_NEXT(a_last_gives_item, clock, reset, req_acc && req_tlast, rsp_tvalid)
   `ASSERT_NEXT(a_no_spurious_item, clock, reset, req_acc && !req_tlast && rsp_free, !rsp_tvalid)
   `ASSERT_IMPL(a_err_value_zero, clock, reset, rsp_tvalid && status != StatusOk, value == '0)
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind hex_text_to_signed_int_unit htsi_checker u_htsi_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
